### sv/kle_pkg.sv
// Package for the keyboard line editor: scan codes, key maps, result codes
// and the command item passed from the front end to the back end.
// Used by every module of the block but kle_ram; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package kle_pkg;

  // Set-1 scan codes that the editor handles by name.
  localparam logic [7:0] SC_BACKSPACE = 8'h0E;
  localparam logic [7:0] SC_ENTER     = 8'h1C;
  localparam logic [7:0] SC_CTRL      = 8'h1D;
  localparam logic [7:0] SC_LETTER_L  = 8'h26;
  localparam logic [7:0] SC_SHIFT_L   = 8'h2A;
  localparam logic [7:0] SC_SHIFT_R   = 8'h36;
  localparam logic [7:0] SC_ALT       = 8'h38;
  localparam logic [7:0] SC_SPACE     = 8'h39;
  localparam logic [7:0] SC_CAPS      = 8'h3A;
  localparam logic [7:0] SC_CTRL_UP   = 8'h9D;
  localparam logic [7:0] SC_L_UP      = 8'hA6;
  localparam logic [7:0] SC_SHL_UP    = 8'hAA;
  localparam logic [7:0] SC_SHR_UP    = 8'hB6;
  localparam logic [7:0] SC_ALT_UP    = 8'hB8;
  localparam logic [7:0] SC_F1        = 8'd59;
  localparam logic [7:0] SC_F3        = 8'd61;
  localparam logic [7:0] KEY_COUNT    = 8'd61;

  // Characters with a fixed meaning.
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Key maps, one character per key from scan code 1 upwards; first key in the MSBs.
  localparam int MAP_KEYS = 61;
  localparam logic [8*MAP_KEYS-1:0] PLAIN_MAP =
      " 1234567890-=  qwertyuiop[]  asdfghjkl;'` \\zxcvbnm,./        ";
  localparam logic [8*MAP_KEYS-1:0] UPPER_MAP =
      " !@#$%^&*()_+  QWERTYUIOP{}  ASDFGHJKL:\"~ |ZXCVBNM<>?        ";

  // Result event codes.
  localparam logic [2:0] EV_ECHO    = 3'd0;
  localparam logic [2:0] EV_BKSP    = 3'd1;
  localparam logic [2:0] EV_DONE    = 3'd2;
  localparam logic [2:0] EV_REDRAW  = 3'd3;
  localparam logic [2:0] EV_SWITCH  = 3'd4;
  localparam logic [2:0] EV_READ    = 3'd5;

  // Width of the command argument: a line position or index up to 255, or a terminal.
  localparam int ARG_W = 8;

  // Depth of the command queue between front and back end.
  localparam int QUEUE_DEPTH = 2;

  // Work that the back end carries out.
  typedef enum logic [2:0] {
    K_READ   = 3'd0,
    K_ECHO   = 3'd1,
    K_BKSP   = 3'd2,
    K_ENTER  = 3'd3,
    K_REDRAW = 3'd4,
    K_SWITCH = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       chr;   // character to append for an echo
    logic [ARG_W-1:0] arg;   // read index, or new terminal for a switch
    logic             oob;   // read index lies past the line store
  } cmd_t;

  // Control key state; codes are one-hot.
  typedef enum logic [2:0] {
    CM_IDLE  = 3'b001,
    CM_CTRL  = 3'b010,
    CM_LHELD = 3'b100
  } ctrl_mode_t;

  // Letter keys follow shift XOR caps lock; key index is scan code minus one.
  function automatic logic is_letter(input logic [5:0] idx);
    return (idx >= 6'd15 && idx <= 6'd24) || (idx >= 6'd29 && idx <= 6'd37) ||
           (idx >= 6'd43 && idx <= 6'd49);
  endfunction

  function automatic logic [7:0] map_plain(input logic [5:0] idx);
    return PLAIN_MAP[8*(MAP_KEYS-1-int'(idx)) +: 8];
  endfunction

  function automatic logic [7:0] map_upper(input logic [5:0] idx);
    return UPPER_MAP[8*(MAP_KEYS-1-int'(idx)) +: 8];
  endfunction

endpackage

`default_nettype wire

### sv/kle_ram.sv
// Generic single-port RAM with a registered read port.
// Read data changes only on a read access. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module kle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 384
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle: a write, or a read into the output register.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

### sv/kle_front.sv
// Front end of the line editor: accepts items, tracks modifier keys and turns
// items that need work into back end commands. Depends on kle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kle_front import kle_pkg::*; #(
  parameter int LINE_CAP  = 128,
  parameter int TERMINALS = 3
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       opcode,
  input  wire logic [7:0] key_code,
  input  wire logic [6:0] read_index,
  input  wire logic       q_full,
  output logic            q_push,
  output cmd_t            q_cmd
);

  logic       shift_held, shift_held_next;
  logic       caps_on, caps_on_next;
  logic       alt_held, alt_held_next;
  ctrl_mode_t ctrl_mode, ctrl_mode_next;

  logic       accept;
  logic       has_cmd;
  logic [5:0] key_idx;
  logic [1:0] new_term;
  logic       use_upper;
  logic [7:0] key_char;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept && has_cmd;

  // Key index, terminal for Alt-Fn and the mapped character.
  always_comb begin
    key_idx   = 6'(key_code - 8'd1);
    new_term  = 2'(key_code - SC_F1);
    use_upper = is_letter(key_idx) ? (shift_held ^ caps_on) : shift_held;
    key_char  = use_upper ? map_upper(key_idx) : map_plain(key_idx);
  end

  // Classify the item and work out the next modifier state.
  always_comb begin
    shift_held_next = shift_held;
    caps_on_next    = caps_on;
    alt_held_next   = alt_held;
    ctrl_mode_next  = ctrl_mode;
    has_cmd         = 1'b0;
    q_cmd.kind      = K_READ;
    q_cmd.chr       = CHAR_NUL;
    q_cmd.arg       = ARG_W'(read_index);
    q_cmd.oob       = (9'(read_index) >= 9'(LINE_CAP));
    if (opcode) begin
      has_cmd = 1'b1;
    end else begin
      unique case (key_code) inside
        SC_ENTER: begin
          has_cmd    = 1'b1;
          q_cmd.kind = K_ENTER;
        end
        SC_BACKSPACE: begin
          has_cmd    = 1'b1;
          q_cmd.kind = K_BKSP;
        end
        SC_CTRL: begin
          if (ctrl_mode == CM_LHELD) begin
            ctrl_mode_next = CM_IDLE;
            has_cmd        = 1'b1;
            q_cmd.kind     = K_REDRAW;
          end else begin
            ctrl_mode_next = CM_CTRL;
          end
        end
        SC_ALT:                 alt_held_next   = 1'b1;
        SC_ALT_UP:              alt_held_next   = 1'b0;
        SC_CTRL_UP, SC_L_UP:    ctrl_mode_next  = CM_IDLE;
        SC_SHIFT_L, SC_SHIFT_R: shift_held_next = 1'b1;
        SC_SHL_UP, SC_SHR_UP:   shift_held_next = 1'b0;
        SC_CAPS:                caps_on_next    = !caps_on;
        SC_SPACE: begin
          has_cmd    = 1'b1;
          q_cmd.kind = K_ECHO;
          q_cmd.chr  = CHAR_SPACE;
        end
        default: begin
          if (key_code == 8'd0 || key_code > KEY_COUNT) begin
            has_cmd = 1'b0;
          end else if (ctrl_mode == CM_CTRL) begin
            // Control combinations print nothing; Ctrl-L asks for a redraw.
            if (key_code == SC_LETTER_L) begin
              ctrl_mode_next = CM_IDLE;
              has_cmd        = 1'b1;
              q_cmd.kind     = K_REDRAW;
            end
          end else if (alt_held && key_code >= SC_F1 && key_code <= SC_F3) begin
            if (3'(new_term) < 3'(TERMINALS)) begin
              has_cmd    = 1'b1;
              q_cmd.kind = K_SWITCH;
              q_cmd.arg  = ARG_W'(new_term);
            end
          end else begin
            if (key_code == SC_LETTER_L) begin
              ctrl_mode_next = CM_LHELD;
            end
            if (key_char != CHAR_SPACE) begin
              has_cmd    = 1'b1;
              q_cmd.kind = K_ECHO;
              q_cmd.chr  = key_char;
            end
          end
        end
      endcase
    end
  end

  // Modifier registers move only on an accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= 1'b0;
      caps_on    <= 1'b0;
      alt_held   <= 1'b0;
      ctrl_mode  <= CM_IDLE;
    end else if (accept) begin
      shift_held <= shift_held_next;
      caps_on    <= caps_on_next;
      alt_held   <= alt_held_next;
      ctrl_mode  <= ctrl_mode_next;
    end
  end

endmodule

`default_nettype wire

### sv/kle_queue.sv
// Short command queue between the front end and the back end.
// Depends on kle_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module kle_queue import kle_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t wcmd,
  output logic      full,
  output logic      valid,
  input  wire logic pop,
  output cmd_t      rcmd
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign rcmd  = entries[rd_ptr];

  // Pointers wrap at the depth; the count tracks the fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wcmd;
    end
  end

endmodule

`default_nettype wire

### sv/kle_back.sv
// Back end of the line editor: carries out commands against the terminal
// line positions and the line store, and holds the output register.
// Depends on kle_pkg and kle_ram.
`timescale 1ns / 1ps
`default_nettype none

module kle_back import kle_pkg::*; #(
  parameter int LINE_CAP  = 128,
  parameter int TERMINALS = 3
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_valid,
  input  wire cmd_t       q_cmd,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      event_res,
  output logic [7:0]      char_code,
  output logic [1:0]      terminal,
  output logic [6:0]      line_length
);

  localparam int PW    = $clog2(LINE_CAP);
  localparam int TSW   = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
  localparam int DEPTH = TERMINALS * (2 ** PW);
  localparam int AW    = $clog2(DEPTH);

  logic [PW-1:0]  pos [TERMINALS];
  logic [TSW-1:0] active;

  logic           exec;
  logic           out_space;
  logic [TSW-1:0] psel;
  logic [PW-1:0]  p;

  logic           res_valid;
  logic [2:0]     res_ev;
  logic [7:0]     res_chr;
  logic [PW-1:0]  res_len;
  logic           pos_we;
  logic [PW-1:0]  pos_wval;
  logic           term_we;
  logic           ram_en;
  logic           ram_we;
  logic [AW-1:0]  ram_addr;
  logic [7:0]     ram_wdata;
  logic [7:0]     ram_rdata;

  logic [2:0]     out_ev;
  logic [7:0]     out_chr;
  logic [TSW-1:0] out_term;
  logic [PW-1:0]  out_len;
  logic           out_rd;
  logic           out_rd_zero;

  // A command runs when the output register is free or being emptied.
  assign out_space = !out_valid || !out_stall;
  assign exec      = q_valid && out_space;
  assign q_pop     = exec;

  // A switch looks at the new terminal's position, everything else at the active one.
  assign psel = (q_cmd.kind == K_SWITCH) ? q_cmd.arg[TSW-1:0] : active;
  assign p    = pos[psel];

  // Command execution.
  always_comb begin
    res_valid = 1'b0;
    res_ev    = EV_ECHO;
    res_chr   = CHAR_NUL;
    res_len   = p;
    pos_we    = 1'b0;
    pos_wval  = p;
    term_we   = 1'b0;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = AW'({active, p});
    ram_wdata = q_cmd.chr;
    unique case (q_cmd.kind)
      K_READ: begin
        res_valid = 1'b1;
        res_ev    = EV_READ;
        ram_en    = 1'b1;
        ram_addr  = AW'({active, q_cmd.arg[PW-1:0]});
      end
      K_ECHO: begin
        // A full line keeps one place for the newline.
        if (p < PW'(LINE_CAP - 1)) begin
          res_valid = 1'b1;
          res_ev    = EV_ECHO;
          res_chr   = q_cmd.chr;
          res_len   = p + 1'b1;
          pos_we    = 1'b1;
          pos_wval  = p + 1'b1;
          ram_en    = 1'b1;
          ram_we    = 1'b1;
        end
      end
      K_BKSP: begin
        if (p != '0) begin
          res_valid = 1'b1;
          res_ev    = EV_BKSP;
          res_chr   = CHAR_BS;
          res_len   = p - 1'b1;
          pos_we    = 1'b1;
          pos_wval  = p - 1'b1;
        end
      end
      K_ENTER: begin
        res_valid = 1'b1;
        res_ev    = EV_DONE;
        res_chr   = CHAR_NL;
        pos_we    = 1'b1;
        pos_wval  = '0;
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_wdata = CHAR_NL;
      end
      K_REDRAW: begin
        res_valid = 1'b1;
        res_ev    = EV_REDRAW;
      end
      K_SWITCH: begin
        res_valid = 1'b1;
        res_ev    = EV_SWITCH;
        term_we   = 1'b1;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  kle_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .en   (exec && ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // Terminal state and line positions.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      for (int i = 0; i < TERMINALS; i++) begin
        pos[i] <= '0;
      end
    end else if (exec) begin
      if (pos_we) begin
        pos[active] <= pos_wval;
      end
      if (term_we) begin
        active <= psel;
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_space) begin
      out_valid <= exec && res_valid;
    end
  end

  // Output register payload; read data comes from the RAM output register.
  always_ff @(posedge clk) begin
    if (exec) begin
      out_ev      <= res_ev;
      out_chr     <= res_chr;
      out_term    <= term_we ? psel : active;
      out_len     <= res_len;
      out_rd      <= (q_cmd.kind == K_READ);
      out_rd_zero <= q_cmd.oob;
    end
  end

  assign event_res   = out_ev;
  assign char_code   = out_rd ? (out_rd_zero ? CHAR_NUL : ram_rdata) : out_chr;
  assign terminal    = 2'(out_term);
  assign line_length = 7'(out_len);

`ifndef SYNTHESIS
  a_term_range: assert property (@(posedge clk) disable iff (rst)
    3'(active) < 3'(TERMINALS))
    else $error("active terminal out of range");

  a_pos_cap: assert property (@(posedge clk) disable iff (rst)
    pos[active] <= PW'(LINE_CAP - 1))
    else $error("line position past the line capacity");

  a_enter_clears: assert property (@(posedge clk) disable iff (rst)
    (exec && q_cmd.kind == K_ENTER) |=> (pos[active] == '0))
    else $error("line position not cleared after line done");
`endif

endmodule

`default_nettype wire

### sv/keyboard_line_editor_core.sv
// Keyboard line editor: set-1 scan codes to ASCII with per-terminal line editing.
// An accepted item's command is written into the command queue; the back end takes it
// from there and registers its result in the output register when that has space.
// Throughput: one item per cycle; in_stall rises only when the command queue fills
// because out_stall holds the output register.
// Reset clears the modifier keys, selects terminal 0 and empties every line;
// the line store itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module keyboard_line_editor_core import kle_pkg::*; #(
  parameter int LINE_CAP  = 128,
  parameter int TERMINALS = 3
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       opcode,
  input  wire logic [7:0] key_code,
  input  wire logic [6:0] read_index,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      event_res,
  output logic [7:0]      char_code,
  output logic [1:0]      terminal,
  output logic [6:0]      line_length
);

  logic q_full;
  logic q_push;
  cmd_t q_wcmd;
  logic q_valid;
  logic q_pop;
  cmd_t q_rcmd;

  // Front end: modifier tracking and classification.
  kle_front #(
    .LINE_CAP (LINE_CAP),
    .TERMINALS(TERMINALS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .key_code  (key_code),
    .read_index(read_index),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_wcmd)
  );

  // Command queue.
  kle_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wcmd (q_wcmd),
    .full (q_full),
    .valid(q_valid),
    .pop  (q_pop),
    .rcmd (q_rcmd)
  );

  // Back end: line editing, line store and output register.
  kle_back #(
    .LINE_CAP (LINE_CAP),
    .TERMINALS(TERMINALS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (q_rcmd),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_res  (event_res),
    .char_code  (char_code),
    .terminal   (terminal),
    .line_length(line_length)
  );

endmodule

`default_nettype wire
